FILE: src/cubic_root_bisection_core_defines.svh
// assertion macros for the cubic root bisection core
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef CUBIC_ROOT_BISECTION_CORE_DEFINES_SVH
`define CUBIC_ROOT_BISECTION_CORE_DEFINES_SVH

// property that must hold in the same cycle as its antecedent
`define CRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its antecedent
`define CRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/crb_pkg.sv
// shared types, widths and constants of the cubic root bisection core
// no dependencies
package crb_pkg;

  // fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 28;
  localparam int CFG_W     = 48;
  localparam int TOL_W     = 27;
  localparam int CFG_IDX_W = 2;

  // horner datapath: operand split into digits for the shared multiplier
  localparam int DIG_W     = 26;
  localparam int N_DIG     = 3;
  localparam int DIG_IDX_W = 2;
  localparam int OP_W      = DIG_W * N_DIG;
  localparam int PROD_W    = DIG_W + 1 + IN_W;
  localparam int ACC_W     = CFG_W + 2 * IN_W + 2;

  // microprogram counter
  localparam int UPC_W = 5;

  // register reset values
  localparam logic signed [CFG_W-1:0] COEF_SQ_RESET =
    CFG_W'(64'sd15 * (64'sd1 <<< FRAC_BITS));
  localparam logic signed [CFG_W-1:0] COEF_LIN_RESET =
    CFG_W'(-64'sd1500 * (64'sd1 <<< FRAC_BITS));
  localparam logic signed [CFG_W-1:0] COEF_CONST_RESET =
    CFG_W'(64'sd12500 * (64'sd1 <<< FRAC_BITS));
  localparam logic [TOL_W-1:0] TOL_RESET =
    TOL_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SQUARE    = 2'd0,
    CFG_LINEAR    = 2'd1,
    CFG_CONSTANT  = 2'd2,
    CFG_TOLERANCE = 2'd3
  } cfg_idx_e;

  // sequencing operation of a control word
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_JUMP     = 3'd1,
    SEQ_CALL     = 3'd2,
    SEQ_RET      = 3'd3,
    SEQ_WAIT_IN  = 3'd4,
    SEQ_WAIT_OUT = 3'd5
  } seq_e;

  // jump condition
  typedef enum logic [2:0] {
    COND_ALWAYS  = 3'd0,
    COND_NO_ROOT = 3'd1,
    COND_NARROW  = 3'd2,
    COND_TINY    = 3'd3,
    COND_ZERO    = 3'd4
  } cond_e;

  // evaluation point source
  typedef enum logic [1:0] {
    X_HOLD     = 2'd0,
    X_LOWER_IN = 2'd1,
    X_UPPER    = 2'd2,
    X_MID      = 2'd3
  } xsel_e;

  // multiplicand register source
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_SEED = 2'd1,
    OP_ACC  = 2'd2
  } opsel_e;

  // accumulator source
  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LIN   = 2'd1,
    ACC_CONST = 2'd2,
    ACC_ADD   = 2'd3
  } accsel_e;

  // bisection control action
  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_ACCEPT  = 4'd1,
    ACT_SIGN_A  = 4'd2,
    ACT_SIGN_B  = 4'd3,
    ACT_MID     = 4'd4,
    ACT_SPLIT   = 4'd5,
    ACT_TINY    = 4'd6,
    ACT_HIT     = 4'd7,
    ACT_NO_ROOT = 4'd8,
    ACT_RESULT  = 4'd9
  } act_e;

  // one control word of the microprogram
  typedef struct packed {
    seq_e                  seq;
    cond_e                 cond;
    logic [UPC_W-1:0]      target;
    xsel_e                 x_sel;
    opsel_e                op_sel;
    accsel_e               acc_sel;
    logic                  mul_en;
    logic [DIG_IDX_W-1:0]  dig;
    act_e                  act;
  } uop_t;

  localparam uop_t UOP_NOP = '{
    seq:     SEQ_NEXT,
    cond:    COND_ALWAYS,
    target:  '0,
    x_sel:   X_HOLD,
    op_sel:  OP_HOLD,
    acc_sel: ACC_HOLD,
    mul_en:  1'b0,
    dig:     '0,
    act:     ACT_NONE
  };

  // status fed to the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic no_root;
    logic narrow;
    logic tiny;
    logic zero;
  } cond_t;

  // sign of the evaluated cubic
  typedef struct packed {
    logic neg;
    logic zero;
  } stat_t;

endpackage

FILE: src/crb_sequencer.sv
// microprogram sequencer: step counter, return register and control store
// depends on crb_pkg
module crb_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crb_pkg::cond_t cond_i,
  output crb_pkg::uop_t  uop_o
);

  localparam int UpcW = crb_pkg::UPC_W;

  // entry points of the program
  localparam logic [UpcW-1:0] A_IDLE    = UpcW'(0);
  localparam logic [UpcW-1:0] A_LOOP    = UpcW'(6);
  localparam logic [UpcW-1:0] A_TINY    = UpcW'(12);
  localparam logic [UpcW-1:0] A_HIT     = UpcW'(13);
  localparam logic [UpcW-1:0] A_NO_ROOT = UpcW'(14);
  localparam logic [UpcW-1:0] A_DONE    = UpcW'(15);
  localparam logic [UpcW-1:0] A_EVAL    = UpcW'(16);

  // control store
  function automatic crb_pkg::uop_t rom_read(input logic [UpcW-1:0] addr);
    crb_pkg::uop_t u;
    u = crb_pkg::UOP_NOP;
    unique case (addr)
      // wait for a bound pair, evaluate at the lower bound
      UpcW'(0): begin
        u.seq   = crb_pkg::SEQ_WAIT_IN;
        u.x_sel = crb_pkg::X_LOWER_IN;
        u.act   = crb_pkg::ACT_ACCEPT;
      end
      UpcW'(1): begin
        u.seq    = crb_pkg::SEQ_CALL;
        u.target = A_EVAL;
      end
      UpcW'(2): begin
        u.x_sel = crb_pkg::X_UPPER;
        u.act   = crb_pkg::ACT_SIGN_A;
      end
      UpcW'(3): begin
        u.seq    = crb_pkg::SEQ_CALL;
        u.target = A_EVAL;
      end
      UpcW'(4): begin
        u.act = crb_pkg::ACT_SIGN_B;
      end
      UpcW'(5): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.cond   = crb_pkg::COND_NO_ROOT;
        u.target = A_NO_ROOT;
      end
      // halving loop
      UpcW'(6): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.cond   = crb_pkg::COND_NARROW;
        u.target = A_DONE;
      end
      UpcW'(7): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.cond   = crb_pkg::COND_TINY;
        u.target = A_TINY;
      end
      UpcW'(8): begin
        u.x_sel = crb_pkg::X_MID;
        u.act   = crb_pkg::ACT_MID;
      end
      UpcW'(9): begin
        u.seq    = crb_pkg::SEQ_CALL;
        u.target = A_EVAL;
      end
      UpcW'(10): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.cond   = crb_pkg::COND_ZERO;
        u.target = A_HIT;
        u.act    = crb_pkg::ACT_SPLIT;
      end
      UpcW'(11): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.target = A_LOOP;
      end
      // exits
      UpcW'(12): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.target = A_DONE;
        u.act    = crb_pkg::ACT_TINY;
      end
      UpcW'(13): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.target = A_DONE;
        u.act    = crb_pkg::ACT_HIT;
      end
      UpcW'(14): begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.target = A_DONE;
        u.act    = crb_pkg::ACT_NO_ROOT;
      end
      UpcW'(15): begin
        u.seq    = crb_pkg::SEQ_WAIT_OUT;
        u.target = A_IDLE;
        u.act    = crb_pkg::ACT_RESULT;
      end
      // cubic evaluation, first horner pass: (x + c2) * x + c1
      UpcW'(16): begin
        u.op_sel  = crb_pkg::OP_SEED;
        u.acc_sel = crb_pkg::ACC_LIN;
      end
      UpcW'(17): begin
        u.mul_en = 1'b1;
        u.dig    = crb_pkg::DIG_IDX_W'(0);
      end
      UpcW'(18): begin
        u.acc_sel = crb_pkg::ACC_ADD;
        u.mul_en  = 1'b1;
        u.dig     = crb_pkg::DIG_IDX_W'(1);
      end
      UpcW'(19): begin
        u.acc_sel = crb_pkg::ACC_ADD;
        u.mul_en  = 1'b1;
        u.dig     = crb_pkg::DIG_IDX_W'(2);
      end
      UpcW'(20): begin
        u.acc_sel = crb_pkg::ACC_ADD;
      end
      // second horner pass: t * x + c0
      UpcW'(21): begin
        u.op_sel  = crb_pkg::OP_ACC;
        u.acc_sel = crb_pkg::ACC_CONST;
      end
      UpcW'(22): begin
        u.mul_en = 1'b1;
        u.dig    = crb_pkg::DIG_IDX_W'(0);
      end
      UpcW'(23): begin
        u.acc_sel = crb_pkg::ACC_ADD;
        u.mul_en  = 1'b1;
        u.dig     = crb_pkg::DIG_IDX_W'(1);
      end
      UpcW'(24): begin
        u.acc_sel = crb_pkg::ACC_ADD;
        u.mul_en  = 1'b1;
        u.dig     = crb_pkg::DIG_IDX_W'(2);
      end
      UpcW'(25): begin
        u.seq     = crb_pkg::SEQ_RET;
        u.acc_sel = crb_pkg::ACC_ADD;
      end
      default: begin
        u.seq    = crb_pkg::SEQ_JUMP;
        u.target = A_IDLE;
      end
    endcase
    return u;
  endfunction

  logic [UpcW-1:0] upc_q, upc_d;
  logic [UpcW-1:0] ret_q, ret_d;
  logic [UpcW-1:0] upc_inc;
  logic            take;
  crb_pkg::uop_t   uop;

  assign uop   = rom_read(upc_q);
  assign uop_o = uop;

  // condition select and next step
  always_comb begin
    upc_inc = upc_q + UpcW'(1);
    unique case (uop.cond)
      crb_pkg::COND_ALWAYS:  take = 1'b1;
      crb_pkg::COND_NO_ROOT: take = cond_i.no_root;
      crb_pkg::COND_NARROW:  take = cond_i.narrow;
      crb_pkg::COND_TINY:    take = cond_i.tiny;
      crb_pkg::COND_ZERO:    take = cond_i.zero;
      default:               take = 1'b0;
    endcase
    upc_d = upc_q;
    ret_d = ret_q;
    unique case (uop.seq)
      crb_pkg::SEQ_NEXT: upc_d = upc_inc;
      crb_pkg::SEQ_JUMP: upc_d = take ? uop.target : upc_inc;
      crb_pkg::SEQ_CALL: begin
        upc_d = uop.target;
        ret_d = upc_inc;
      end
      crb_pkg::SEQ_RET: upc_d = ret_q;
      crb_pkg::SEQ_WAIT_IN: begin
        if (cond_i.in_fire) upc_d = upc_inc;
      end
      crb_pkg::SEQ_WAIT_OUT: begin
        if (cond_i.out_free) upc_d = uop.target;
      end
      default: upc_d = A_IDLE;
    endcase
  end

  // step counter and return register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
      ret_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
      ret_q <= ret_d;
    end
  end

endmodule

FILE: src/crb_eval_dp.sv
// horner datapath for the cubic sign: one 27x28 multiplier shared by digits
// depends on crb_pkg; driven by control words from crb_sequencer
module crb_eval_dp (
  input  logic                               clk_i,
  input  crb_pkg::uop_t                      uop_i,
  input  logic signed [crb_pkg::IN_W-1:0]    x_i,
  input  logic signed [crb_pkg::CFG_W-1:0]   coef_sq_i,
  input  logic signed [crb_pkg::CFG_W-1:0]   coef_lin_i,
  input  logic signed [crb_pkg::CFG_W-1:0]   coef_const_i,
  output crb_pkg::stat_t                     stat_o
);

  localparam int InW    = crb_pkg::IN_W;
  localparam int DigW   = crb_pkg::DIG_W;
  localparam int OpW    = crb_pkg::OP_W;
  localparam int ProdW  = crb_pkg::PROD_W;
  localparam int AccW   = crb_pkg::ACC_W;
  localparam int DigIdx = crb_pkg::DIG_IDX_W;
  localparam int ShW    = $clog2(OpW);

  logic signed [InW-1:0]   x_q;
  logic        [OpW-1:0]   op_q, op_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] prod_q;
  logic        [DigIdx-1:0] pd_q;

  logic        [DigW-1:0]  dig_bits;
  logic                    top_dig;
  logic signed [DigW:0]    mul_a;
  logic signed [ProdW-1:0] mul_p;
  logic signed [OpW-1:0]   seed;
  logic signed [AccW-1:0]  prod_ext;
  logic        [ShW-1:0]   sh_amt;
  logic signed [AccW-1:0]  lin_term;
  logic signed [AccW-1:0]  const_term;

  // digit of the multiplicand; only the top digit carries the sign
  assign dig_bits = op_q[uop_i.dig * DigW +: DigW];
  assign top_dig  = (uop_i.dig == DigIdx'(crb_pkg::N_DIG - 1));
  assign mul_a    = $signed({top_dig & dig_bits[DigW-1], dig_bits});
  assign mul_p    = mul_a * x_q;

  // aligned partial product and coefficient terms
  assign sh_amt     = ShW'(pd_q * DigW);
  assign prod_ext   = AccW'(prod_q) << sh_amt;
  assign seed       = OpW'(x_q) + OpW'(coef_sq_i);
  assign lin_term   = AccW'(coef_lin_i) <<< crb_pkg::FRAC_BITS;
  assign const_term = AccW'(coef_const_i) <<< (2 * crb_pkg::FRAC_BITS);

  // multiplicand and accumulator selection
  always_comb begin
    unique case (uop_i.op_sel)
      crb_pkg::OP_SEED: op_d = seed;
      crb_pkg::OP_ACC:  op_d = acc_q[OpW-1:0];
      default:          op_d = op_q;
    endcase
    unique case (uop_i.acc_sel)
      crb_pkg::ACC_HOLD:  acc_d = acc_q;
      crb_pkg::ACC_LIN:   acc_d = lin_term;
      crb_pkg::ACC_CONST: acc_d = const_term;
      crb_pkg::ACC_ADD:   acc_d = acc_q + prod_ext;
      default:            acc_d = acc_q;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (uop_i.x_sel != crb_pkg::X_HOLD) x_q <= x_i;
    op_q  <= op_d;
    acc_q <= acc_d;
    if (uop_i.mul_en) begin
      prod_q <= mul_p;
      pd_q   <= uop_i.dig;
    end
  end

  assign stat_o.neg  = acc_q[AccW-1];
  assign stat_o.zero = (acc_q == '0);

endmodule

FILE: src/cubic_root_bisection_core.sv
// cubic root bisection core: top level with config registers and bisection control
// an accepted bound pair has both ends evaluated, then its interval is halved up to about
// 28 times, with one more evaluation per halving; each cubic evaluation runs two horner
// passes on the shared 27x28 multiplier
// one bound pair in work at a time; the next is taken once the result is registered
// reset: registers take their default values, sequencer idles, no result is pending
`include "cubic_root_bisection_core_defines.svh"

module cubic_root_bisection_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [crb_pkg::CFG_W-1:0]            cfg_wdata_i,
  // bound pair request
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [crb_pkg::IN_W-1:0]      lower_bound_i,
  input  logic signed [crb_pkg::IN_W-1:0]      upper_bound_i,
  // result request
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [crb_pkg::IN_W-1:0]      root_o,
  output logic                                 no_root_o,
  output logic                                 exact_zero_o
);

  localparam int InW   = crb_pkg::IN_W;
  localparam int CfgW  = crb_pkg::CFG_W;
  localparam int TolW  = crb_pkg::TOL_W;
  localparam int DiffW = InW + 1;

  crb_pkg::uop_t  uop;
  crb_pkg::cond_t cond;
  crb_pkg::stat_t stat;

  logic signed [CfgW-1:0] coef_sq_q, coef_lin_q, coef_const_q;
  logic        [TolW-1:0] tol_q;
  logic        [TolW-1:0] tol_eff;

  logic signed [InW-1:0]  a_q, b_q, c_q;
  logic                   sa_neg_q, sa_zero_q, sb_neg_q, sb_zero_q;
  logic                   hit_q, nr_q;
  logic                   out_valid_q;
  logic signed [InW-1:0]  root_q;
  logic                   no_root_q, exact_zero_q;

  logic signed [DiffW-1:0] diff;
  logic signed [InW-1:0]   mid;
  logic signed [InW-1:0]   x_val;
  logic                    in_fire, out_fire, out_free;
  logic                    accept, res_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_sq_q    <= crb_pkg::COEF_SQ_RESET;
      coef_lin_q   <= crb_pkg::COEF_LIN_RESET;
      coef_const_q <= crb_pkg::COEF_CONST_RESET;
      tol_q        <= crb_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (crb_pkg::cfg_idx_e'(cfg_idx_i))
        crb_pkg::CFG_SQUARE:    coef_sq_q    <= $signed(cfg_wdata_i);
        crb_pkg::CFG_LINEAR:    coef_lin_q   <= $signed(cfg_wdata_i);
        crb_pkg::CFG_CONSTANT:  coef_const_q <= $signed(cfg_wdata_i);
        crb_pkg::CFG_TOLERANCE: tol_q        <= cfg_wdata_i[TolW-1:0];
      endcase
    end
  end

  // handshakes
  assign in_stall_o = (uop.seq != crb_pkg::SEQ_WAIT_IN);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_fire && (uop.act == crb_pkg::ACT_ACCEPT);
  assign res_load   = out_free && (uop.act == crb_pkg::ACT_RESULT);

  // interval width, midpoint and loop conditions
  assign tol_eff = (tol_q == '0) ? TolW'(1) : tol_q;
  assign diff    = DiffW'(b_q) - DiffW'(a_q);
  assign mid     = a_q + $signed(diff[InW:1]);

  assign cond.in_fire  = in_fire;
  assign cond.out_free = out_free;
  assign cond.no_root  = sa_zero_q || sb_zero_q || (sa_neg_q == sb_neg_q);
  assign cond.narrow   = diff < $signed(DiffW'(tol_eff));
  assign cond.tiny     = diff < $signed(DiffW'(2));
  assign cond.zero     = stat.zero;

  // evaluation point
  always_comb begin
    unique case (uop.x_sel)
      crb_pkg::X_LOWER_IN: x_val = lower_bound_i;
      crb_pkg::X_UPPER:    x_val = b_q;
      crb_pkg::X_MID:      x_val = mid;
      default:             x_val = a_q;
    endcase
  end

  crb_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .uop_o  (uop)
  );

  crb_eval_dp u_eval (
    .clk_i        (clk_i),
    .uop_i        (uop),
    .x_i          (x_val),
    .coef_sq_i    (coef_sq_q),
    .coef_lin_i   (coef_lin_q),
    .coef_const_i (coef_const_q),
    .stat_o       (stat)
  );

  // bounds, midpoint and end signs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= lower_bound_i;
      b_q <= upper_bound_i;
      c_q <= lower_bound_i;
    end
    unique case (uop.act)
      crb_pkg::ACT_SIGN_A: begin
        sa_neg_q  <= stat.neg;
        sa_zero_q <= stat.zero;
      end
      crb_pkg::ACT_SIGN_B: begin
        sb_neg_q  <= stat.neg;
        sb_zero_q <= stat.zero;
      end
      crb_pkg::ACT_MID: c_q <= mid;
      crb_pkg::ACT_SPLIT: begin
        if (stat.neg != sa_neg_q) b_q <= c_q;
        else a_q <= c_q;
      end
      crb_pkg::ACT_TINY: c_q <= a_q;
      default: ;
    endcase
  end

  // outcome flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      nr_q  <= 1'b0;
    end else if (accept) begin
      hit_q <= 1'b0;
      nr_q  <= 1'b0;
    end else if (uop.act == crb_pkg::ACT_HIT) begin
      hit_q <= 1'b1;
    end else if (uop.act == crb_pkg::ACT_NO_ROOT) begin
      nr_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      root_q       <= nr_q ? '0 : c_q;
      no_root_q    <= nr_q;
      exact_zero_q <= hit_q && !nr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign no_root_o    = no_root_q;
  assign exact_zero_o = exact_zero_q;

  // checks
  `CRB_ASSERT_NEXT(a_one_item, in_fire, in_stall_o, "bound pair taken while another is in work")
  `CRB_ASSERT_NOW(a_result_step, $rose(out_valid_q), $past(uop.seq == crb_pkg::SEQ_WAIT_OUT), "result raised outside the result step")
  `CRB_ASSERT_NOW(a_no_root_clean, out_valid_o && no_root_o, (root_o == '0) && !exact_zero_o, "no-root result carries a root")

endmodule

FILE: tb/crb_result_checker.sv
// result checker for the cubic root bisection core: mirrors the registers,
// predicts each bisection and compares every result; depends on crb_pkg
module crb_result_checker
  import crb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [IN_W-1:0]  lower_bound_i,
  input  logic signed [IN_W-1:0]  upper_bound_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [IN_W-1:0]  root_i,
  input  logic                    no_root_i,
  input  logic                    exact_zero_i,
  output int                      err_cnt_o,
  output int                      pending_o,
  output int                      result_cnt_o,
  output int                      no_root_cnt_o,
  output int                      hit_cnt_o
);

  // one outstanding request with the result it should produce
  typedef struct packed {
    logic signed [IN_W-1:0] lower;
    logic signed [IN_W-1:0] upper;
    logic signed [IN_W-1:0] root;
    logic                   no_root;
    logic                   exact_zero;
  } root_req_t;

  logic signed [CFG_W-1:0] coef_sq_q;
  logic signed [CFG_W-1:0] coef_lin_q;
  logic signed [CFG_W-1:0] coef_const_q;
  logic [TOL_W-1:0]        tol_q;

  root_req_t expected_roots[$];
  root_req_t head;

  // sign of the cubic at x, evaluated exactly with 3*FRAC_BITS fraction bits
  function automatic int cubic_sign(input logic signed [IN_W-1:0] x);
    logic signed [127:0] xw, x2, acc, sq_w, lin_w, cn_w;
    xw    = 128'(x);
    sq_w  = 128'(coef_sq_q);
    lin_w = 128'(coef_lin_q);
    cn_w  = 128'(coef_const_q);
    x2    = xw * xw;
    acc   = x2 * xw + sq_w * x2 + ((lin_w * xw) <<< FRAC_BITS)
          + (cn_w <<< (2 * FRAC_BITS));
    if (acc < 0) return -1;
    if (acc == 0) return 0;
    return 1;
  endfunction

  // bisection of one bound pair under the mirrored registers
  function automatic root_req_t bisect_bracket(input logic signed [IN_W-1:0] lo,
                                               input logic signed [IN_W-1:0] up);
    root_req_t r;
    longint    a, b, c, d, tol;
    int        sa, sb, sc;
    a = longint'(lo);
    b = longint'(up);
    tol = longint'(tol_q);
    if (tol == 0) tol = 1;
    r.lower      = lo;
    r.upper      = up;
    r.root       = '0;
    r.no_root    = 1'b1;
    r.exact_zero = 1'b0;
    sa = cubic_sign(lo);
    sb = cubic_sign(up);
    // a bound on a zero or equal end signs: nothing bracketed
    if (sa == 0 || sb == 0 || sa == sb) return r;
    r.no_root = 1'b0;
    c = a;
    while (b - a >= tol) begin
      d = b - a;
      // one lsb apart, cannot split further
      if (d < 2) begin
        c = a;
        break;
      end
      c  = a + d / 2;
      sc = cubic_sign(c[IN_W-1:0]);
      if (sc == 0) begin
        r.exact_zero = 1'b1;
        break;
      end
      if (sc != sa) b = c;
      else a = c;
    end
    r.root = c[IN_W-1:0];
    return r;
  endfunction

  // register mirror, expectation store and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_sq_q     <= COEF_SQ_RESET;
      coef_lin_q    <= COEF_LIN_RESET;
      coef_const_q  <= COEF_CONST_RESET;
      tol_q         <= TOL_RESET;
      expected_roots.delete();
      err_cnt_o     <= 0;
      pending_o     <= 0;
      result_cnt_o  <= 0;
      no_root_cnt_o <= 0;
      hit_cnt_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SQUARE:    coef_sq_q    <= cfg_wdata_i;
          CFG_LINEAR:    coef_lin_q   <= cfg_wdata_i;
          CFG_CONSTANT:  coef_const_q <= cfg_wdata_i;
          CFG_TOLERANCE: tol_q        <= cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end

      // results first: a result never belongs to a request taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_roots.size() == 0) begin
          if (err_cnt_o < 10)
            $display("unexpected result: root %0d no_root %0b exact_zero %0b",
                     root_i, no_root_i, exact_zero_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          head = expected_roots.pop_front();
          if (head.no_root) no_root_cnt_o <= no_root_cnt_o + 1;
          if (head.exact_zero) hit_cnt_o <= hit_cnt_o + 1;
          if (root_i !== head.root || no_root_i !== head.no_root ||
              exact_zero_i !== head.exact_zero) begin
            if (err_cnt_o < 10) begin
              $display("mismatch for bounds %0d, %0d: expected root %0d no_root %0b %s",
                       head.lower, head.upper, head.root, head.no_root, "and");
              $display("  exact_zero %0b, got root %0d no_root %0b exact_zero %0b",
                       head.exact_zero, root_i, no_root_i, exact_zero_i);
            end
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        expected_roots.push_back(bisect_bracket(lower_bound_i, upper_bound_i));

      pending_o <= expected_roots.size();
    end
  end

endmodule

FILE: tb/tb_cubic_root_bisection_core.sv
// testbench top for the cubic root bisection core: directed and random bound pairs
// under many register settings; depends on crb_pkg, crb_result_checker and the core
module tb_cubic_root_bisection_core;
  import crb_pkg::*;

  localparam longint ONE         = 64'sd1 <<< FRAC_BITS;
  localparam longint IN_MAX      = (64'sd1 <<< (IN_W - 1)) - 1;
  localparam longint IN_MIN      = -(64'sd1 <<< (IN_W - 1));
  localparam logic signed [IN_W-1:0] BOUND_MAX = IN_W'(IN_MAX);
  localparam logic signed [IN_W-1:0] BOUND_MIN = IN_W'(IN_MIN);
  localparam logic signed [CFG_W-1:0] CFG_MAX = {1'b0, {(CFG_W-1){1'b1}}};
  localparam logic signed [CFG_W-1:0] CFG_MIN = {1'b1, {(CFG_W-1){1'b0}}};
  localparam int     RANDOM_PAIRS = 1250;
  localparam int     LONG_HOLD    = 2500;
  localparam int     DRAIN_CYCLES = 600;
  localparam int     CYCLE_LIMIT  = 4000000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [IN_W-1:0] lower_bound;
  logic signed [IN_W-1:0] upper_bound;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [IN_W-1:0] root;
  logic                   no_root;
  logic                   exact_zero;

  int err_cnt, pending, result_cnt, no_root_cnt, hit_cnt;
  int pairs_sent;
  int settings_cnt;
  int cycle_cnt;
  bit no_gaps;
  int root_q[3];

  cubic_root_bisection_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .lower_bound_i (lower_bound),
    .upper_bound_i (upper_bound),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .root_o        (root),
    .no_root_o     (no_root),
    .exact_zero_o  (exact_zero)
  );

  crb_result_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .lower_bound_i (lower_bound),
    .upper_bound_i (upper_bound),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .root_i        (root),
    .no_root_i     (no_root),
    .exact_zero_i  (exact_zero),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .result_cnt_o  (result_cnt),
    .no_root_cnt_o (no_root_cnt),
    .hit_cnt_o     (hit_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // integer value to signed q12.16
  function automatic logic signed [IN_W-1:0] fx(input longint v);
    return IN_W'(v * ONE);
  endfunction

  function automatic logic signed [IN_W-1:0] clamp_in(input longint v);
    if (v > IN_MAX) v = IN_MAX;
    if (v < IN_MIN) v = IN_MIN;
    return IN_W'(v);
  endfunction

  // random coefficient of random magnitude
  function automatic logic signed [CFG_W-1:0] rand_coef();
    logic signed [CFG_W-1:0] v;
    v = CFG_W'({$urandom, $urandom});
    return v >>> $urandom_range(0, 40);
  endfunction

  function automatic logic signed [CFG_W-1:0] pick_coef();
    case ($urandom_range(0, 3))
      0:       return CFG_MAX;
      1:       return CFG_MIN;
      2:       return '0;
      default: return rand_coef();
    endcase
  endfunction

  function automatic logic [TOL_W-1:0] pick_tolerance();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return TOL_W'($urandom_range(1, 100));
    if (r < 75) return TOL_W'($urandom_range(1, 4000));
    if (r < 85) return TOL_W'(1);
    if (r < 90) return '0;
    if (r < 95) return '1;
    return TOL_W'($urandom_range(1, 134217727));
  endfunction

  // bounds around a center, spans of random magnitude, sometimes reversed
  function automatic void make_bracket(input longint center,
                                       output logic signed [IN_W-1:0] lo,
                                       output logic signed [IN_W-1:0] up);
    longint      a, b, mask;
    int unsigned k;
    k    = $urandom_range(0, IN_W - 1);
    mask = (64'sd1 <<< k) - 1;
    a    = center - (longint'($urandom) & mask);
    b    = center + (longint'($urandom) & mask);
    if ($urandom_range(0, 9) == 0) begin
      lo = clamp_in(b);
      up = clamp_in(a);
    end else begin
      lo = clamp_in(a);
      up = clamp_in(b);
    end
  endfunction

  // write all four registers, block must be idle
  task automatic program_regs(input logic signed [CFG_W-1:0] sq, lin, cn,
                              input logic [TOL_W-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SQUARE;
    cfg_wdata <= sq;
    @(posedge clk);
    cfg_idx   <= CFG_LINEAR;
    cfg_wdata <= lin;
    @(posedge clk);
    cfg_idx   <= CFG_CONSTANT;
    cfg_wdata <= cn;
    @(posedge clk);
    cfg_idx   <= CFG_TOLERANCE;
    cfg_wdata <= CFG_W'(tol);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_cnt++;
  endtask

  // offer one bound pair request and hold it until accepted
  task automatic send_pair(input logic signed [IN_W-1:0] lo, up);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    lower_bound <= lo;
    upper_bound <= up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, free stretches, one long hold-off
  initial begin
    int  stall_left;
    int  free_left;
    int  hold_cycles;
    bit  long_hold_done;
    stall_left     = 0;
    free_left      = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && result_cnt >= 150) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clk);
        stall_left = 0;
        free_left  = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 30) free_left = $urandom_range(20, 300);
        else stall_left = idle_len();
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    logic signed [IN_W-1:0] lo, up, noise_pt;
    longint                 c2, c1, c0;
    int                     directed_cnt;
    int                     kind, mode, n_items;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_SQUARE;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    lower_bound <= '0;
    upper_bound <= '0;
    no_gaps      = 1'b0;
    pairs_sent   = 0;
    settings_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset cubic, roots at -50, 10 and 25, tolerance 66
    send_pair(fx(0), fx(20));               // midpoint lands on a root
    send_pair(fx(0), fx(15));
    send_pair(fx(-60), fx(-40));
    send_pair(fx(20), fx(30));
    send_pair(fx(0), fx(5));                // same sign at both ends
    send_pair(fx(10), fx(12));              // bound on a root
    send_pair(fx(15), fx(0));               // reversed, signs differ
    send_pair(fx(5), fx(0));                // reversed, same sign
    send_pair(fx(10) - IN_W'(10), fx(10) + IN_W'(20)); // already narrower than tolerance
    send_pair(BOUND_MIN, BOUND_MAX);
    send_pair(BOUND_MAX, BOUND_MIN);
    send_pair(BOUND_MIN, BOUND_MIN);
    send_pair(BOUND_MAX, BOUND_MAX);
    send_pair(fx(0), fx(0));
    wait_idle();

    // x^3 - 2 with tolerance 1: irrational root, ends on a one lsb interval
    program_regs('0, '0, CFG_W'(-2 * ONE), TOL_W'(1));
    send_pair(fx(1), fx(2));
    send_pair(fx(-3), fx(2));
    wait_idle();

    // zero tolerance acts as one
    program_regs('0, '0, CFG_W'(-2 * ONE), '0);
    send_pair(fx(1) + IN_W'(5), fx(2));
    wait_idle();

    // plain x^3 with the largest tolerance
    program_regs('0, '0, '0, '1);
    send_pair(BOUND_MIN, BOUND_MAX);
    send_pair(fx(-1), fx(3));
    wait_idle();

    // extreme coefficients
    program_regs(CFG_MAX, CFG_MIN, CFG_MAX, TOL_RESET);
    send_pair(BOUND_MIN, BOUND_MAX);
    send_pair(fx(-1), fx(1));
    wait_idle();
    program_regs(CFG_MIN, CFG_MAX, CFG_MIN, TOL_W'(1));
    send_pair(BOUND_MIN, BOUND_MAX);
    send_pair(fx(0), BOUND_MAX);
    wait_idle();
    directed_cnt = pairs_sent;

    // random phases, each under a fresh register setting
    while (pairs_sent < directed_cnt + RANDOM_PAIRS) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // cubic with three known roots on a quarter grid
        for (int i = 0; i < 3; i++) root_q[i] = int'($urandom_range(0, 8000)) - 4000;
        c2 = -(longint'(root_q[0]) + root_q[1] + root_q[2]) * 16384;
        c1 = (longint'(root_q[0]) * root_q[1] + longint'(root_q[0]) * root_q[2]
              + longint'(root_q[1]) * root_q[2]) * 4096;
        c0 = -(longint'(root_q[0]) * root_q[1] * root_q[2]) * 1024;
        program_regs(CFG_W'(c2), CFG_W'(c1), CFG_W'(c0), pick_tolerance());
      end else if (kind < 8) begin
        program_regs(rand_coef(), rand_coef(), rand_coef(), pick_tolerance());
      end else begin
        program_regs(pick_coef(), pick_coef(), pick_coef(), pick_tolerance());
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(20, 120);
      repeat (n_items) begin
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
          lo = IN_W'($urandom);
          up = IN_W'($urandom);
        end else if (kind < 6) begin
          make_bracket(longint'(root_q[$urandom_range(0, 2)]) * 16384, lo, up);
        end else begin
          noise_pt = IN_W'($urandom);
          make_bracket(longint'(noise_pt), lo, up);
        end
        send_pair(lo, up);
      end
      wait_idle();
    end

    // settle and report
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bound pairs (%0d directed) under %0d register settings after reset",
             pairs_sent, directed_cnt, settings_cnt);
    $display("%0d results compared: %0d without a root, %0d stopped on an exact zero",
             result_cnt, no_root_cnt, hit_cnt);
    if (err_cnt == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
